[rtl/bbd_pkg.sv]
// ----------------------------------------------------------------------------
// bbd_pkg: shared types and constants for the Bayer demosaic core
// Field widths, register indexes and reset values, the per-pixel control
// word passed to the interpolator, and the window column type.
// ----------------------------------------------------------------------------
package bbd_pkg;

    // Sample and field widths
    localparam int PIX_W      = 8;
    localparam int PATTERN_W  = 2;
    localparam int FWIDTH_W   = 13;
    localparam int FHEIGHT_W  = 15;
    localparam int ROW_W      = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam int MAX_HEIGHT = 16384;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT  = 2'd2;

    // Configuration reset values
    localparam logic [PATTERN_W-1:0] RST_PATTERN = 2'd0;
    localparam logic [FWIDTH_W-1:0]  RST_FWIDTH  = 13'd640;
    localparam logic [FHEIGHT_W-1:0] RST_FHEIGHT = 15'd480;

    // Color of the raw sample at the output position
    typedef enum logic [1:0] {
        SITE_RED,
        SITE_BLUE,
        SITE_GREEN_RROW,
        SITE_GREEN_BROW
    } t_site;

    // One window column; element r is window row r (0 top, 2 bottom)
    typedef logic [2:0][PIX_W-1:0] t_col;

    // Per-pixel control handed from the sequencer to the interpolator
    typedef struct packed {
        t_site site;
        logic  left_clamp;   // output on the first column
        logic  right_clamp;  // output on the last column
        logic  first_col_in; // input at column zero: right column not yet shifted in
        logic  top_clamp;    // output on the first row
        logic  bot_clamp;    // output on the last row
        logic  last;         // bottom-right pixel of the frame
    } t_pix_ctrl;

endpackage

[rtl/bbd_if.sv]
// ----------------------------------------------------------------------------
// bbd_if: valid/ready channels of the Bayer demosaic core
// Raw pixel input, RGB result output and configuration write channel.
// ----------------------------------------------------------------------------
interface bbd_pix_if import bbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output mode, output pixel_value, input ready);
    modport sink   (input valid, input mode, input pixel_value, output ready);
endinterface

interface bbd_rgb_if import bbd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             last_of_frame;

    modport source (output valid, output red, output green, output blue,
                    output last_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input last_of_frame, output ready);
endinterface

interface bbd_cfg_if import bbd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bbd_ram.sv]
// ----------------------------------------------------------------------------
// bbd_ram: simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/bbd_interp.sv]
// ----------------------------------------------------------------------------
// bbd_interp: bilinear interpolation of one output pixel
// Selects the 3x3 neighborhood with edge clamping and forms the truncated
// two- and four-sample means for the site color.
// ----------------------------------------------------------------------------
module bbd_interp import bbd_pkg::*; (
    input  t_pix_ctrl        i_ctrl,
    input  t_col             i_left,
    input  t_col             i_center,
    input  t_col             i_new,
    output logic [PIX_W-1:0] o_red,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_blue
);

    t_col             col_l;
    t_col             col_r;
    logic [1:0]       row_t;
    logic [1:0]       row_b;
    logic [PIX_W-1:0] ctr;
    logic [PIX_W:0]   hs;
    logic [PIX_W:0]   vs;
    logic [PIX_W+1:0] hv;
    logic [PIX_W+1:0] dg;

    always_comb begin
        col_l = i_ctrl.left_clamp ? i_center : i_left;
        // right neighbor not shifted in yet at an input column zero
        col_r = (i_ctrl.right_clamp || i_ctrl.first_col_in) ? i_center : i_new;
        row_t = i_ctrl.top_clamp ? 2'd1 : 2'd0;
        row_b = i_ctrl.bot_clamp ? 2'd1 : 2'd2;

        ctr = i_center[1];
        hs  = {1'b0, col_l[1]} + {1'b0, col_r[1]};
        vs  = {1'b0, i_center[row_t]} + {1'b0, i_center[row_b]};
        hv  = {1'b0, hs} + {1'b0, vs};
        dg  = {2'b00, col_l[row_t]} + {2'b00, col_r[row_t]}
            + {2'b00, col_l[row_b]} + {2'b00, col_r[row_b]};

        unique case (i_ctrl.site)
            SITE_RED: begin
                o_red   = ctr;
                o_green = hv[PIX_W+1:2];
                o_blue  = dg[PIX_W+1:2];
            end
            SITE_BLUE: begin
                o_blue  = ctr;
                o_green = hv[PIX_W+1:2];
                o_red   = dg[PIX_W+1:2];
            end
            SITE_GREEN_RROW: begin
                o_green = ctr;
                o_red   = hs[PIX_W:1];
                o_blue  = vs[PIX_W:1];
            end
            default: begin
                o_green = ctr;
                o_blue  = hs[PIX_W:1];
                o_red   = vs[PIX_W:1];
            end
        endcase
    end

endmodule

[rtl/bayer_bilinear_demosaic_core.sv]
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core: streaming bilinear Bayer demosaic, 8 bits
// Raw Bayer samples in raster order in, one RGB pixel per sample out.
// ----------------------------------------------------------------------------
// The core takes one raw transaction per clock and sustains that rate
// indefinitely; a transaction is held off only while a finished RGB result
// sits in the output register and the sink does not take it. From accept
// to result register: the line memory is read at the accepting edge, then
// in stage 1 the sample is merged, the 3x3 window shifted and the pixel
// interpolated, and the result register loads as soon as stage 1
// advances. In stream order each result belongs to the sample
// frame_width+1 positions earlier; after the last raw sample of a frame,
// send frame_width+1 flush transactions (mode = 1) to release the tail, the
// final one carrying last_of_frame. A flush inside the frame is taken and
// dropped; a raw sample during the tail counts as a flush. The two rows
// above the current one live in a single MAX_WIDTH x 16 line memory
// (older and newer sample side by side), read and rewritten once per
// sample at the current column; a write that coincides with the read of
// the same entry is forwarded. The memory needs no clearing after reset.
// Configuration (pattern, width, height) must be written between frames
// or while the stream is idle; widths above MAX_WIDTH act as MAX_WIDTH.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core import bbd_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbd_cfg_if.sink   i_cfg,
    bbd_pix_if.sink   i_pix,
    bbd_rgb_if.source o_rgb
);

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int MW_W    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W   = ((MW_W > FWIDTH_W) ? MW_W : FWIDTH_W) + 1;
    localparam int ROW_CW  = ROW_W + 1;
    localparam int LINE_W  = 2 * PIX_W;

    // Configuration
    logic [PATTERN_W-1:0] r_pattern;
    logic [FWIDTH_W-1:0]  r_fwidth;
    logic [FHEIGHT_W-1:0] r_fheight;

    // Position counters
    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;

    // Stage 1 (line memory data returns)
    logic             r_s1_valid;
    logic             r_s1_wr;
    logic             r_s1_emit;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_addr;
    t_pix_ctrl        r_s1_ctrl;

    // Forwarding of a write that lands on the edge of a read
    logic              r_fwd_hit;
    logic [LINE_W-1:0] r_fwd_data;

    // Window: column 2 newest
    t_col r_win [3];

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_red;
    logic [PIX_W-1:0] r_out_green;
    logic [PIX_W-1:0] r_out_blue;
    logic             r_out_last;

    logic [CMP_W-1:0]  fw_ext;
    logic [CMP_W-1:0]  w_used;
    logic [ROW_CW-1:0] fh_ext;
    logic [ROW_CW-1:0] h_used;
    logic              pix_acc;
    logic              tail;
    logic              proc;
    logic              col_wrap;
    logic              emit;
    logic              out_col_end;
    logic              out_row_end;
    logic              last;
    logic              red_row;
    logic              red_col;
    t_pix_ctrl         ctrl;
    logic              s1_adv;
    logic              out_load;
    logic              fwd_match;
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_data;
    logic [LINE_W-1:0] wr_data;
    logic [PIX_W-1:0]  top_px;
    logic [PIX_W-1:0]  mid_px;
    logic [PIX_W-1:0]  bot_px;
    t_col              new_col;
    logic [PIX_W-1:0]  pix_red;
    logic [PIX_W-1:0]  pix_green;
    logic [PIX_W-1:0]  pix_blue;

    // ------------------------------------------------------------------------
    // Configuration port: always ready, unknown indexes dropped
    // ------------------------------------------------------------------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern <= RST_PATTERN;
            r_fwidth  <= RST_FWIDTH;
            r_fheight <= RST_FHEIGHT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_IDX_PATTERN: r_pattern <= i_cfg.data[PATTERN_W-1:0];
                CFG_IDX_WIDTH:   r_fwidth  <= i_cfg.data[FWIDTH_W-1:0];
                CFG_IDX_HEIGHT:  r_fheight <= i_cfg.data[FHEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp width to 1..MAX_WIDTH and height to 1..MAX_HEIGHT
    always_comb begin
        fw_ext = CMP_W'(r_fwidth);
        if (fw_ext == '0) begin
            w_used = CMP_W'(1);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            w_used = CMP_W'(MAX_WIDTH);
        end else begin
            w_used = fw_ext;
        end

        fh_ext = ROW_CW'(r_fheight);
        if (fh_ext == '0) begin
            h_used = ROW_CW'(1);
        end else if (fh_ext > ROW_CW'(MAX_HEIGHT)) begin
            h_used = ROW_CW'(MAX_HEIGHT);
        end else begin
            h_used = fh_ext;
        end
    end

    // ------------------------------------------------------------------------
    // Stage 0: decode the accepted transaction, advance positions
    // ------------------------------------------------------------------------
    assign pix_acc = i_pix.valid && i_pix.ready;
    assign tail    = ROW_CW'(r_in_row) >= h_used;
    // drop a flush that arrives before the frame is complete
    assign proc    = pix_acc && !(i_pix.mode && !tail);

    assign col_wrap    = (CMP_W'(r_in_col) + CMP_W'(1)) >= w_used;
    assign emit        = (r_in_row != '0) && ((r_in_col != '0) || (r_in_row >= ROW_W'(2)));
    assign out_col_end = (CMP_W'(r_out_col) + CMP_W'(1)) >= w_used;
    assign out_row_end = (ROW_CW'(r_out_row) + ROW_CW'(1)) >= h_used;
    assign last        = emit && out_col_end && out_row_end;

    // pattern bit 1: row parity of red, bit 0: column parity of red
    assign red_row = r_out_row[0] == r_pattern[1];
    assign red_col = r_out_col[0] == r_pattern[0];

    always_comb begin
        priority if (red_row && red_col) begin
            ctrl.site = SITE_RED;
        end else if (!red_row && !red_col) begin
            ctrl.site = SITE_BLUE;
        end else if (red_row) begin
            ctrl.site = SITE_GREEN_RROW;
        end else begin
            ctrl.site = SITE_GREEN_BROW;
        end
        ctrl.left_clamp   = r_out_col == '0;
        ctrl.right_clamp  = out_col_end;
        ctrl.first_col_in = r_in_col == '0;
        ctrl.top_clamp    = r_out_row == '0;
        ctrl.bot_clamp    = out_row_end;
        ctrl.last         = last;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (proc) begin
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = ROW_W'(r_in_row + ROW_W'(1));
            end else begin
                n_in_col = COL_W'(r_in_col + COL_W'(1));
            end
            if (last) begin
                // frame done: restart every position
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else if (emit) begin
                if (out_col_end) begin
                    n_out_col = '0;
                    n_out_row = ROW_W'(r_out_row + ROW_W'(1));
                end else begin
                    n_out_col = COL_W'(r_out_col + COL_W'(1));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ------------------------------------------------------------------------
    // Flow control: stage 1 stalls only when it holds a result and the
    // output register is full and not being taken
    // ------------------------------------------------------------------------
    assign s1_adv      = r_s1_valid && (!r_s1_emit || !r_out_valid || o_rgb.ready);
    assign i_pix.ready = !r_s1_valid || s1_adv;
    assign out_load    = s1_adv && r_s1_emit;

    // Stage 1 write lands on the same edge as the new read of that entry
    assign fwd_match = r_s1_valid && s1_adv && r_s1_wr && (r_s1_addr == r_in_col);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            if (proc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (proc || s1_adv) begin
                r_fwd_hit <= proc && fwd_match;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_s1_wr    <= !tail;
            r_s1_emit  <= emit;
            r_s1_px    <= i_pix.pixel_value;
            r_s1_addr  <= r_in_col;
            r_s1_ctrl  <= ctrl;
            r_fwd_data <= wr_data;
        end
    end

    // ------------------------------------------------------------------------
    // Line memory: {older, newer} per column, read at accept, rewritten
    // in stage 1 as {newer, incoming}
    // ------------------------------------------------------------------------
    bbd_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk     (i_clk),
        .i_we      (s1_adv && r_s1_wr),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (wr_data),
        .i_re      (proc),
        .i_rd_addr (r_in_col),
        .o_rd_data (ram_rd_data)
    );

    assign line_data = r_fwd_hit ? r_fwd_data : ram_rd_data;
    assign top_px    = line_data[LINE_W-1:PIX_W];
    assign mid_px    = line_data[PIX_W-1:0];
    // tail transactions feed zeros into the bottom row
    assign bot_px    = r_s1_wr ? r_s1_px : '0;
    assign wr_data   = {mid_px, r_s1_px};
    assign new_col   = {bot_px, mid_px, top_px};

    // ------------------------------------------------------------------------
    // Stage 1: window shift and interpolation
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
            r_win[2] <= '0;
        end else if (s1_adv) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= new_col;
        end
    end

    // Center is the newest column before the shift; left the one before it
    bbd_interp u_interp (
        .i_ctrl   (r_s1_ctrl),
        .i_left   (r_win[1]),
        .i_center (r_win[2]),
        .i_new    (new_col),
        .o_red    (pix_red),
        .o_green  (pix_green),
        .o_blue   (pix_blue)
    );

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rgb.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_red   <= pix_red;
            r_out_green <= pix_green;
            r_out_blue  <= pix_blue;
            r_out_last  <= r_s1_ctrl.last;
        end
    end

    assign o_rgb.valid         = r_out_valid;
    assign o_rgb.red           = r_out_red;
    assign o_rgb.green         = r_out_green;
    assign o_rgb.blue          = r_out_blue;
    assign o_rgb.last_of_frame = r_out_last;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && last) |=> (r_in_col == '0 && r_in_row == '0 &&
                            r_out_col == '0 && r_out_row == '0))
        else $error("positions not restarted after the frame's last pixel");

    a_fwd_needs_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> r_s1_valid)
        else $error("forwarded line data with an empty stage 1");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (r_out_valid && !o_rgb.ready && r_s1_emit))
        else $error("input held off without a blocked result");

endmodule

[tb/bayer_bilinear_demosaic_core_test.sv]
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic_core_test: self-checking bench for the demosaic core
// Drives raw Bayer frames and flush transactions under random back-pressure,
// predicts every RGB pixel with a behavioral demosaic and compares each result
// field by field, across all mosaic orders, zero sizes and frames up to 8x6.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic_core_test;
    import bbd_pkg::*;

    localparam int MAX_W       = 4096;
    localparam int SETTLE      = 8;     // cycles past the last result before a write
    localparam int HOLD_OFF    = 300;   // long sink stall to back up the core
    localparam int STALL_LIMIT = 2000;  // cycles without any transaction
    localparam int RANDOM_FEED = 160;   // pixel transactions per idling mode

    localparam logic MODE_RAW   = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_rgb;

    typedef enum logic [1:0] {
        STEP_CFG,
        STEP_RAW,
        STEP_FLUSH
    } t_step;

    typedef struct {
        t_step                 kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] value;  // register data, or the sample in [7:0]
        bit                    typed;  // result of this transaction is given below
        t_rgb                  want;
    } t_plan_row;

    localparam t_rgb NO_RGB  = '0;
    localparam t_rgb SAT     = '{8'hFF, 8'hFF, 8'hFF, 1'b0};
    localparam t_rgb SAT_END = '{8'hFF, 8'hFF, 8'hFF, 1'b1};
    localparam t_rgb DARK_1  = '{8'h00, 8'h00, 8'h00, 1'b1};
    localparam t_rgb A5_1    = '{8'hA5, 8'hA5, 8'hA5, 1'b1};

    localparam int PLAN_LEN = 36;

    // Directed frames. A saturated frame gives saturated pixels everywhere,
    // and a 1x1 frame returns its only sample on all three colors, so those
    // results are typed in; the mixed 2x2 frame goes through the predictor.
    t_plan_row plan [PLAN_LEN] = '{
        // RGGB 3x2 all 255, with a stray flush inside the frame and a raw
        // sample in the tail that must act as a flush
        '{STEP_CFG,   CFG_IDX_PATTERN, 15'd0,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_WIDTH,   15'd3,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_HEIGHT,  15'd2,   1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h5A,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b1, SAT},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFF,  1'b1, SAT},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b1, SAT},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h00,  1'b1, SAT},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b1, SAT},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b1, SAT_END},
        // BGGR single pixel of zero; the first flush yields nothing
        '{STEP_CFG,   CFG_IDX_PATTERN, 15'd3,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_WIDTH,   15'd1,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_HEIGHT,  15'd1,   1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h00,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b1, DARK_1},
        // GRBG with width and height zero, both acting as one
        '{STEP_CFG,   CFG_IDX_PATTERN, 15'd1,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_WIDTH,   15'd0,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_HEIGHT,  15'd0,   1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hA5,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'hFF,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b1, A5_1},
        // GBRG 2x2 with mixed samples
        '{STEP_CFG,   CFG_IDX_PATTERN, 15'd2,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_WIDTH,   15'd2,   1'b0, NO_RGB},
        '{STEP_CFG,   CFG_IDX_HEIGHT,  15'd2,   1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h01,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h80,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'hFE,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h7F,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b0, NO_RGB},
        '{STEP_FLUSH, CFG_IDX_PATTERN, 15'h00,  1'b0, NO_RGB},
        '{STEP_RAW,   CFG_IDX_PATTERN, 15'h33,  1'b0, NO_RGB}
    };

    logic i_clk;
    logic i_rst_n;

    bbd_cfg_if cfg_ch ();
    bbd_pix_if pix_ch ();
    bbd_rgb_if rgb_ch ();

    bayer_bilinear_demosaic_core #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_pix   (pix_ch),
        .o_rgb   (rgb_ch)
    );

    // ------------------------------------------------------------------
    // Demosaic predictor state: register copies, line rows, 3x3 window and
    // the input/output raster positions
    // ------------------------------------------------------------------
    logic [PATTERN_W-1:0] cfg_pattern = RST_PATTERN;
    logic [FWIDTH_W-1:0]  cfg_width   = RST_FWIDTH;
    logic [FHEIGHT_W-1:0] cfg_height  = RST_FHEIGHT;

    bit [PIX_W-1:0] older_row [MAX_W];
    bit [PIX_W-1:0] newer_row [MAX_W];
    t_col           win [3];             // [0] oldest column, [2] newest
    int unsigned    in_col, in_row, out_col, out_row;

    t_rgb           pending_rgb [$];     // RGB pixels still owed by the core

    // Sideband that travels with each pixel transaction
    bit             row_typed;
    t_rgb           row_exp;

    int             tx_idle_pct, rx_idle_pct;
    bit             stall_req;
    int unsigned    cur_w, cur_h;        // frame size the stimulus works to
    int             n_err, n_fed, n_rgb, n_frames, n_writes;

    function automatic int unsigned eff_width(input logic [FWIDTH_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_W) return MAX_W;
        return v;
    endfunction

    function automatic int unsigned eff_height(input logic [FHEIGHT_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_HEIGHT) return MAX_HEIGHT;
        return v;
    endfunction

    // Interpolate the pixel at (out_row, out_col) from window columns lc/cc/rc
    function automatic t_rgb interp(input int unsigned lc, input int unsigned cc,
                                    input int unsigned rc, input int unsigned w,
                                    input int unsigned h);
        int unsigned t, b, ctr, hs, vs, dg, r, g, bl;
        logic        rp, cp;
        t_rgb        px;
        t  = (out_row == 0) ? 1 : 0;
        b  = (out_row + 1 >= h) ? 1 : 2;
        rp = out_row[0];
        cp = out_col[0];
        // Clamp neighbors that fall off the frame to the edge column
        if (out_col == 0) lc = cc;
        if (out_col + 1 >= w) rc = cc;
        ctr = win[cc][1];
        hs  = win[lc][1] + win[rc][1];
        vs  = win[cc][t] + win[cc][b];
        dg  = win[lc][t] + win[rc][t] + win[lc][b] + win[rc][b];
        if (rp == cfg_pattern[1] && cp == cfg_pattern[0]) begin
            r = ctr; g = (hs + vs) / 4; bl = dg / 4;
        end else if (rp != cfg_pattern[1] && cp != cfg_pattern[0]) begin
            bl = ctr; g = (hs + vs) / 4; r = dg / 4;
        end else if (rp == cfg_pattern[1]) begin
            g = ctr; r = hs / 2; bl = vs / 2;
        end else begin
            g = ctr; bl = hs / 2; r = vs / 2;
        end
        px.red   = r[7:0];
        px.green = g[7:0];
        px.blue  = bl[7:0];
        px.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
        return px;
    endfunction

    // Advance the predictor by one accepted pixel transaction
    task automatic demosaic_step(input logic m, input logic [PIX_W-1:0] px,
                                 output bit got, output t_rgb res);
        int unsigned      w, h, ci, ri, idx;
        bit               tail, emit;
        logic [PIX_W-1:0] top, mid, bot;
        w    = eff_width(cfg_width);
        h    = eff_height(cfg_height);
        ci   = in_col;
        ri   = in_row;
        tail = (in_row >= h);
        got  = 1'b0;
        res  = NO_RGB;
        // Drop a flush while the frame is still coming in
        if (m == MODE_FLUSH && !tail) return;
        idx = (ci < MAX_W) ? ci : MAX_W - 1;
        top = older_row[idx];
        mid = newer_row[idx];
        bot = tail ? '0 : px;
        if (!tail) begin
            older_row[idx] = mid;
            newer_row[idx] = px;
        end
        emit = (ri >= 1) && (ci >= 1 || ri >= 2);
        // At column zero the last pixel of the row above is still centered
        if (emit && ci == 0) begin
            res = interp(1, 2, 2, w, h);
            got = 1'b1;
        end
        win[0] = win[1];
        win[1] = win[2];
        win[2] = {bot, mid, top};
        if (emit && ci != 0) begin
            res = interp(0, 1, 2, w, h);
            got = 1'b1;
        end
        if (ci + 1 >= w) begin
            in_col = 0;
            in_row = ri + 1;
        end else begin
            in_col = ci + 1;
        end
        if (got) begin
            if (res.last) begin
                in_col  = 0;
                in_row  = 0;
                out_col = 0;
                out_row = 0;
            end else if (out_col + 1 >= w) begin
                out_col = 0;
                out_row = out_row + 1;
            end else begin
                out_col = out_col + 1;
            end
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [PIX_W-1:0] want_v,
                                 input logic [PIX_W-1:0] got_v);
        n_err++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want_v, got_v);
    endtask

    // ------------------------------------------------------------------
    // Scoreboard: track register writes, predict on every accepted pixel
    // transaction, check every accepted RGB transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : scoreboard
        bit   got;
        t_rgb res;
        t_rgb want;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                n_writes++;
                case (cfg_ch.index)
                    CFG_IDX_PATTERN: cfg_pattern = cfg_ch.data[PATTERN_W-1:0];
                    CFG_IDX_WIDTH:   cfg_width   = cfg_ch.data[FWIDTH_W-1:0];
                    CFG_IDX_HEIGHT:  cfg_height  = cfg_ch.data[FHEIGHT_W-1:0];
                    default: ;
                endcase
            end
            if (pix_ch.valid && pix_ch.ready) begin
                demosaic_step(pix_ch.mode, pix_ch.pixel_value, got, res);
                // A typed-in result stands in for the prediction
                if (row_typed) pending_rgb.push_back(row_exp);
                else if (got) pending_rgb.push_back(res);
            end
            if (rgb_ch.valid && rgb_ch.ready) begin
                n_rgb++;
                if (rgb_ch.last_of_frame === 1'b1) n_frames++;
                if (pending_rgb.size() == 0) begin
                    n_err++;
                    $display({"%0t: RGB result with none pending: expected none, ",
                              "actual %0d/%0d/%0d last %0d"},
                             $time, rgb_ch.red, rgb_ch.green, rgb_ch.blue,
                             rgb_ch.last_of_frame);
                end else begin
                    want = pending_rgb.pop_front();
                    if (rgb_ch.red !== want.red) flag_mismatch("red", want.red, rgb_ch.red);
                    if (rgb_ch.green !== want.green)
                        flag_mismatch("green", want.green, rgb_ch.green);
                    if (rgb_ch.blue !== want.blue) flag_mismatch("blue", want.blue, rgb_ch.blue);
                    if (rgb_ch.last_of_frame !== want.last)
                        flag_mismatch("last_of_frame", PIX_W'(want.last),
                                      PIX_W'(rgb_ch.last_of_frame));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Clock, sink and watchdog
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Sink: random ready, plus one long hold-off on request
    initial begin
        rgb_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                stall_req = 1'b0;
                rgb_ch.ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge i_clk);
            end
            rgb_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // End the run when no channel moves a transaction for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (rgb_ch.valid && rgb_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: timeout, no transaction for %0d cycles, %0d RGB results pending",
                 $time, STALL_LIMIT, pending_rgb.size());
        $display("[bayer_bilinear_demosaic_core] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one pixel transaction after a random gap; hold it until taken
    task automatic offer(input logic m, input logic [PIX_W-1:0] px, input bit typed,
                         input t_rgb want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.mode        <= m;
        pix_ch.pixel_value <= px;
        row_typed          <= typed;
        row_exp            <= want;
        do @(posedge i_clk); while (pix_ch.ready !== 1'b1);
    endtask

    // Stop offering, wait out every owed result, then let the pipe go quiet
    task automatic drain_and_settle();
        pix_ch.valid <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Present one register write; leave valid high for a following write
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
    endtask

    task automatic apply_config(input int pattern, input int wset, input int hset);
        drain_and_settle();
        put_reg(CFG_IDX_PATTERN, CFG_DATA_W'(pattern));
        put_reg(CFG_IDX_WIDTH, CFG_DATA_W'(wset));
        put_reg(CFG_IDX_HEIGHT, CFG_DATA_W'(hset));
        cfg_ch.valid <= 1'b0;
        cur_w = eff_width(FWIDTH_W'(wset));
        cur_h = eff_height(FHEIGHT_W'(hset));
    endtask

    function automatic logic [PIX_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // One whole frame: raw samples with stray flushes mixed in, then the
    // width+1 tail transactions, some of them raw samples that act as flushes
    task automatic send_frame();
        for (int p = 0; p < cur_w * cur_h; p++) begin
            if ($urandom_range(0, 9) == 0)
                offer(MODE_FLUSH, PIX_W'($urandom_range(0, 255)), 1'b0, NO_RGB);
            offer(MODE_RAW, pick_sample(), 1'b0, NO_RGB);
            n_fed++;
        end
        for (int k = 0; k <= cur_w; k++) begin
            if ($urandom_range(0, 4) == 0) offer(MODE_RAW, pick_sample(), 1'b0, NO_RGB);
            else offer(MODE_FLUSH, PIX_W'($urandom_range(0, 255)), 1'b0, NO_RGB);
            n_fed++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        bit cfg_open;
        int fed_mark;
        int wset, hset;

        i_rst_n            <= 1'b0;
        pix_ch.valid       <= 1'b0;
        pix_ch.mode        <= MODE_RAW;
        pix_ch.pixel_value <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_IDX_PATTERN;
        cfg_ch.data        <= '0;
        row_typed          <= 1'b0;
        row_exp            <= NO_RGB;
        stall_req          = 1'b0;
        tx_idle_pct        = 30;
        rx_idle_pct        = 71;
        cfg_open           = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames; register writes only once the core has gone idle
        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) begin
                if (!cfg_open) drain_and_settle();
                put_reg(plan[i].idx, plan[i].value);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_ch.valid <= 1'b0;
                cfg_open = 1'b0;
                offer((plan[i].kind == STEP_FLUSH) ? MODE_FLUSH : MODE_RAW,
                      plan[i].value[PIX_W-1:0], plan[i].typed, plan[i].want);
            end
        end

        // Random frames: sink slow, then sender slow, then neither idles
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 71 : 0;
            rx_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 30 : 0;
            fed_mark    = n_fed;
            if (phase == 2) begin
                // Back the core up: hold the sink off while samples keep coming
                apply_config($urandom_range(0, 3), 8, 6);
                stall_req = 1'b1;
                send_frame();
            end
            while (n_fed - fed_mark < RANDOM_FEED) begin
                wset = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
                hset = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
                apply_config($urandom_range(0, 3), wset, hset);
                repeat (2) send_frame();
            end
        end

        drain_and_settle();
        $display("Covered %0d pixel transactions and %0d RGB results in %0d frames,",
                 n_fed, n_rgb, n_frames);
        $display("with %0d register writes over all four mosaic orders and sizes up to 8x6.",
                 n_writes);
        if (n_err == 0) begin
            $display("[bayer_bilinear_demosaic_core] OK");
        end else begin
            $display("[bayer_bilinear_demosaic_core] ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bbd_pkg.sv
rtl/bbd_if.sv
rtl/bbd_ram.sv
rtl/bbd_interp.sv
rtl/bayer_bilinear_demosaic_core.sv
tb/bayer_bilinear_demosaic_core_test.sv
